// ----- hdl/bhrt_pkg.sv -----
package bhrt_pkg;

	localparam int MAX_BONES_DEF = 64;
	localparam int WORD_W = 32;
	localparam int NCOL = 4;
	localparam int BONE_NUM_W = 6;

	typedef logic [NCOL-1:0][WORD_W-1:0] row_t;
	typedef row_t [NCOL-1:0] mat_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_BAD_PARENT = 2'd1,
		ST_OVER_CAP = 2'd2
	} status_t;

	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} pipe_ld_t;

endpackage

// ----- hdl/bone_hierarchy_to_root_transform.sv -----
// channel | handshake          | payload
// request | req_valid/req_stall | start_skeleton, parent_bone, local_col0..3
// result  | res_valid/res_stall | bone_number, row_number, root_col0..3, status
//
// one row per cycle unless a hazard or a stalled result holds requests; a
// request passes stages s1 to s4 and the output register before its result
// leaves; a row whose parent bone still has rows in the multiply pipeline
// waits until they are written to the store, which takes longer while results are stalled
// arst_n clears counters and valid flags; the matrix store is not cleared
// a stalled result holds the pipeline only as far back as bubbles allow
module bone_hierarchy_to_root_transform #(
	parameter int MAX_BONES = bhrt_pkg::MAX_BONES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               start_skeleton,
	input  logic [5:0]         parent_bone,
	input  logic signed [31:0] local_col0,
	input  logic signed [31:0] local_col1,
	input  logic signed [31:0] local_col2,
	input  logic signed [31:0] local_col3,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [5:0]         bone_number,
	output logic [1:0]         row_number,
	output logic signed [31:0] root_col0,
	output logic signed [31:0] root_col1,
	output logic signed [31:0] root_col2,
	output logic signed [31:0] root_col3,
	output logic [1:0]         status
);

	localparam int BCW = $clog2(MAX_BONES + 1);
	localparam int AW = $clog2(MAX_BONES);
	localparam int XW = BCW + 6;

	typedef struct packed {
		logic [BCW-1:0] bone;
		logic [1:0] row;
		bhrt_pkg::status_t st;
		logic keep;
		logic mul;
	} ctl_t;

	logic [BCW-1:0] bone_q;
	logic [1:0] row_q;
	logic [BCW-1:0] cur_bone;
	logic [1:0] cur_row;
	logic [XW-1:0] par_x;
	logic over, bad, use_par, hazard;
	ctl_t ctl_in;
	bhrt_pkg::row_t loc_in;

	logic v_s1, v_s2, v_s3, v_s4, out_v_q;
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	bhrt_pkg::row_t loc_s1, loc_s2, loc_s3, loc_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, ro;
	logic ld_s1, ld_out;
	bhrt_pkg::pipe_ld_t ld;

	bhrt_pkg::mat_t par_s1;
	bhrt_pkg::row_t lane_root;
	bhrt_pkg::row_t merged;
	logic [XW-1:0] bone_out_x;

	logic [BCW-1:0] out_bone_q;
	logic [1:0] out_row_q;
	bhrt_pkg::row_t out_root_q;
	bhrt_pkg::status_t out_st_q;

	function automatic logic hit(input logic v, input ctl_t c, input logic [XW-1:0] p);
		hit = v && c.keep && (XW'(c.bone) == p);
	endfunction

	// front end: bone and row tracking, capacity and parent checks, hazard detection
	always_comb begin
		cur_bone = start_skeleton ? '0 : bone_q;
		cur_row = start_skeleton ? 2'd0 : row_q;
		par_x = XW'(parent_bone);
		over = cur_bone >= BCW'(MAX_BONES);
		bad = !over && (cur_bone != '0) && (par_x >= XW'(cur_bone));
		use_par = !over && (cur_bone != '0) && !bad;
		loc_in = {local_col3, local_col2, local_col1, local_col0};
		ctl_in.bone = cur_bone;
		ctl_in.row = cur_row;
		ctl_in.keep = !over;
		ctl_in.mul = use_par;
		if (over) begin
			ctl_in.st = bhrt_pkg::ST_OVER_CAP;
		end else if (bad) begin
			ctl_in.st = bhrt_pkg::ST_BAD_PARENT;
		end else begin
			ctl_in.st = bhrt_pkg::ST_OK;
		end
		hazard = use_par && (hit(v_s1, ctl_s1, par_x) || hit(v_s2, ctl_s2, par_x) ||
			hit(v_s3, ctl_s3, par_x) || hit(v_s4, ctl_s4, par_x));
	end

	// pipeline flow control
	always_comb begin
		ro = !out_v_q || !res_stall;
		ld_out = v_s4 && ro;
		rdy_s4 = !v_s4 || ro;
		ld.ld_s4 = v_s3 && rdy_s4;
		rdy_s3 = !v_s3 || rdy_s4;
		ld.ld_s3 = v_s2 && rdy_s3;
		rdy_s2 = !v_s2 || rdy_s3;
		ld.ld_s2 = v_s1 && rdy_s2;
		rdy_s1 = !v_s1 || rdy_s2;
		req_stall = !rdy_s1 || hazard;
		ld_s1 = req_valid && !req_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bone_q <= '0;
			row_q <= 2'd0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (ld_s1) begin
				row_q <= cur_row + 2'd1;
				if (cur_row == 2'd3 && !over) begin
					bone_q <= cur_bone + BCW'(1);
				end else begin
					bone_q <= cur_bone;
				end
			end
			if (rdy_s1) begin
				v_s1 <= ld_s1;
			end
			if (rdy_s2) begin
				v_s2 <= ld.ld_s2;
			end
			if (rdy_s3) begin
				v_s3 <= ld.ld_s3;
			end
			if (rdy_s4) begin
				v_s4 <= ld.ld_s4;
			end
			if (ro) begin
				out_v_q <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			ctl_s1 <= ctl_in;
			loc_s1 <= loc_in;
		end
		if (ld.ld_s2) begin
			ctl_s2 <= ctl_s1;
			loc_s2 <= loc_s1;
		end
		if (ld.ld_s3) begin
			ctl_s3 <= ctl_s2;
			loc_s3 <= loc_s2;
		end
		if (ld.ld_s4) begin
			ctl_s4 <= ctl_s3;
			loc_s4 <= loc_s3;
		end
		if (ld_out) begin
			out_bone_q <= ctl_s4.bone;
			out_row_q <= ctl_s4.row;
			out_root_q <= merged;
			out_st_q <= ctl_s4.st;
		end
	end

	bhrt_store #(.MAX_BONES(MAX_BONES)) u_store (
		.clk   (clk),
		.rd_en (ld_s1),
		.raddr (par_x[AW-1:0]),
		.rdata (par_s1),
		.we    (ld_out && ctl_s4.keep),
		.waddr (ctl_s4.bone[AW-1:0]),
		.wrow  (ctl_s4.row),
		.wdata (merged)
	);

	for (genvar c = 0; c < 4; c++) begin : g_lane
		bhrt_pkg::row_t col;

		always_comb begin
			for (int k = 0; k < 4; k++) begin
				col[k] = par_s1[k][c];
			end
		end

		bhrt_lane u_lane (
			.clk  (clk),
			.ld   (ld),
			.loc  (loc_s1),
			.col  (col),
			.root (lane_root[c])
		);
	end

	// merge lanes with pass-through rows
	always_comb begin
		merged = ctl_s4.mul ? lane_root : loc_s4;
		bone_out_x = XW'(out_bone_q);
	end

	assign res_valid = out_v_q;
	assign bone_number = bone_out_x[5:0];
	assign row_number = out_row_q;
	assign root_col0 = out_root_q[0];
	assign root_col1 = out_root_q[1];
	assign root_col2 = out_root_q[2];
	assign root_col3 = out_root_q[3];
	assign status = out_st_q;

endmodule

// ----- hdl/bhrt_lane.sv -----
module bhrt_lane (
	input  logic                clk,
	input  bhrt_pkg::pipe_ld_t  ld,
	input  bhrt_pkg::row_t      loc,
	input  bhrt_pkg::row_t      col,
	output logic signed [31:0]  root
);

	logic [3:0][63:0] prod_s2;
	logic [1:0][64:0] pair_s3;
	logic [65:0] sum;
	logic signed [31:0] sat;

	always_comb begin
		sum = {pair_s3[0][64], pair_s3[0]} + {pair_s3[1][64], pair_s3[1]};
		if (sum[65] && !(&sum[64:47])) begin
			sat = 32'sh8000_0000;
		end else if (!sum[65] && (|sum[64:47])) begin
			sat = 32'sh7fff_ffff;
		end else begin
			sat = $signed(sum[47:16]);
		end
	end

	always_ff @(posedge clk) begin
		if (ld.ld_s2) begin
			for (int k = 0; k < 4; k++) begin
				prod_s2[k] <= $signed(loc[k]) * $signed(col[k]);
			end
		end
		if (ld.ld_s3) begin
			pair_s3[0] <= {prod_s2[0][63], prod_s2[0]} + {prod_s2[1][63], prod_s2[1]};
			pair_s3[1] <= {prod_s2[2][63], prod_s2[2]} + {prod_s2[3][63], prod_s2[3]};
		end
		if (ld.ld_s4) begin
			root <= sat;
		end
	end

endmodule

// ----- hdl/bhrt_store.sv -----
module bhrt_store #(
	parameter int MAX_BONES = bhrt_pkg::MAX_BONES_DEF,
	localparam int AW = $clog2(MAX_BONES)
) (
	input  logic            clk,
	input  logic            rd_en,
	input  logic [AW-1:0]   raddr,
	output bhrt_pkg::mat_t  rdata,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  logic [1:0]      wrow,
	input  bhrt_pkg::row_t  wdata
);

	bhrt_pkg::mat_t mem [MAX_BONES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr][wrow] <= wdata;
		end
		if (rd_en) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/bhrt_checker.sv -----
module bhrt_checker #(
	parameter int MAX_BONES = bhrt_pkg::MAX_BONES_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_stall,
	input logic [5:0]         bone_number,
	input logic [1:0]         row_number,
	input logic signed [31:0] root_col0,
	input logic signed [31:0] root_col1,
	input logic signed [31:0] root_col2,
	input logic signed [31:0] root_col3,
	input logic [1:0]         status
);

	localparam logic [5:0] OVER_NUM = 6'(MAX_BONES % 64);
	localparam logic NARROW = MAX_BONES <= 64;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(root_col0) && $stable(root_col1) &&
		$stable(root_col2) && $stable(root_col3) && $stable(status) &&
		$stable(bone_number) && $stable(row_number))
		else $error("stalled result changed");

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

	a_root_parent: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && NARROW && status == bhrt_pkg::ST_BAD_PARENT |-> bone_number != 6'd0)
		else $error("root bone flagged with bad parent");

	a_over_bone: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == bhrt_pkg::ST_OVER_CAP |-> bone_number == OVER_NUM)
		else $error("capacity flag on wrong bone number");

endmodule

bind bone_hierarchy_to_root_transform bhrt_checker #(.MAX_BONES(MAX_BONES)) u_bhrt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.bone_number (bone_number),
	.row_number  (row_number),
	.root_col0   (root_col0),
	.root_col1   (root_col1),
	.root_col2   (root_col2),
	.root_col3   (root_col3),
	.status      (status)
);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

	localparam int MAX_BONES = bhrt_pkg::MAX_BONES_DEF;
	localparam logic [31:0] MAXW = 32'h7FFF_FFFF;
	localparam logic [31:0] MINW = 32'h8000_0000;
	localparam logic [31:0] ONE = 32'h0001_0000;

	typedef struct {
		logic [5:0] bone;
		logic [1:0] row;
		bhrt_pkg::row_t cols;
		bhrt_pkg::status_t st;
	} root_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	logic start_skeleton;
	logic [5:0] parent_bone;
	logic signed [31:0] local_col0;
	logic signed [31:0] local_col1;
	logic signed [31:0] local_col2;
	logic signed [31:0] local_col3;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [5:0] bone_number;
	logic [1:0] row_number;
	logic signed [31:0] root_col0;
	logic signed [31:0] root_col1;
	logic signed [31:0] root_col2;
	logic signed [31:0] root_col3;
	logic [1:0] status;

	int send_idle_pct;
	int rcv_idle_pct;
	int hold_cycles;
	int errors;

	// predictor state
	bhrt_pkg::row_t root_store [MAX_BONES*4];
	int cur_bone;
	int cur_row;
	root_row_t pending_rows[$];

	bone_hierarchy_to_root_transform #(.MAX_BONES(MAX_BONES)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.start_skeleton(start_skeleton),
		.parent_bone(parent_bone),
		.local_col0(local_col0),
		.local_col1(local_col1),
		.local_col2(local_col2),
		.local_col3(local_col3),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.bone_number(bone_number),
		.row_number(row_number),
		.root_col0(root_col0),
		.root_col1(root_col1),
		.root_col2(root_col2),
		.root_col3(root_col3),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("tb failed");
		$finish;
	end

	// floor of the Q16.16 dot product, saturated to 32 bits
	function automatic logic [31:0] row_dot(bhrt_pkg::row_t lhs, bhrt_pkg::row_t rhs);
		logic signed [67:0] acc;
		acc = '0;
		for (int k = 0; k < bhrt_pkg::NCOL; k++)
			acc = acc + $signed(lhs[k]) * $signed(rhs[k]);
		acc = acc >>> 16;
		if (acc[67:31] == '0 || acc[67:31] == '1)
			return acc[31:0];
		return acc[67] ? MINW : MAXW;
	endfunction

	function automatic void predict_root_row(input logic st, input logic [5:0] par,
			input bhrt_pkg::row_t loc);
		root_row_t e;
		bhrt_pkg::row_t colv;
		if (st) begin
			cur_bone = 0;
			cur_row = 0;
		end
		e.bone = cur_bone[5:0];
		e.row = cur_row[1:0];
		e.cols = loc;
		e.st = bhrt_pkg::ST_OK;
		if (cur_bone >= MAX_BONES) begin
			e.st = bhrt_pkg::ST_OVER_CAP;
		end else begin
			if (cur_bone != 0) begin
				if (par >= cur_bone) begin
					e.st = bhrt_pkg::ST_BAD_PARENT;
				end else begin
					for (int c = 0; c < bhrt_pkg::NCOL; c++) begin
						for (int k = 0; k < bhrt_pkg::NCOL; k++)
							colv[k] = root_store[par*4 + k][c];
						e.cols[c] = row_dot(loc, colv);
					end
				end
			end
			root_store[cur_bone*4 + cur_row] = e.cols;
		end
		pending_rows.insert(pending_rows.size(), e);
		cur_row = (cur_row + 1) % 4;
		if (cur_row == 0 && cur_bone < MAX_BONES)
			cur_bone++;
	endfunction

	function automatic logic [31:0] rand_word();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(7))
			0: ;
			1: w = w[0] ? MAXW : MINW;
			default: w = {{13{w[18]}}, w[18:0]};
		endcase
		return w;
	endfunction

	function automatic bhrt_pkg::row_t rand_row();
		bhrt_pkg::row_t r;
		for (int c = 0; c < bhrt_pkg::NCOL; c++)
			r[c] = rand_word();
		return r;
	endfunction

	function automatic bhrt_pkg::row_t mk_row(logic [31:0] c0, logic [31:0] c1,
			logic [31:0] c2, logic [31:0] c3);
		return {c3, c2, c1, c0};
	endfunction

	// entered and left at a falling edge; valid stays high for a following request
	task automatic send_row(input logic st, input logic [5:0] par, input bhrt_pkg::row_t loc);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		start_skeleton <= st;
		parent_bone <= par;
		local_col0 <= loc[0];
		local_col1 <= loc[1];
		local_col2 <= loc[2];
		local_col3 <= loc[3];
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predict_root_row(st, par, loc);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			res_stall <= 1'b1;
			hold_cycles--;
		end else begin
			res_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t mismatch %s expected %h actual %h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		root_row_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_rows.size() == 0) begin
				errors++;
				$display("%0t unexpected result expected none actual bone %0d row %0d",
					$time, bone_number, row_number);
			end else begin
				want = pending_rows.pop_front();
				check_field("bone_number", 32'(want.bone), 32'(bone_number));
				check_field("row_number", 32'(want.row), 32'(row_number));
				check_field("root_col0", want.cols[0], root_col0);
				check_field("root_col1", want.cols[1], root_col1);
				check_field("root_col2", want.cols[2], root_col2);
				check_field("root_col3", want.cols[3], root_col3);
				check_field("status", 32'(want.st), 32'(status));
			end
		end
	end

	task automatic test_directed();
		// bone 0 passes through, parent ignored
		send_row(1'b1, 6'd63, mk_row(MAXW, MAXW, MAXW, MAXW));
		send_row(1'b0, 6'd63, mk_row(MINW, MINW, MINW, MINW));
		send_row(1'b0, 6'd0, mk_row(ONE, 32'd0, 32'd0, 32'd0));
		send_row(1'b0, 6'd0, mk_row(32'd0, 32'hFFFF_FFFF, ONE, 32'h0000_8000));
		// bone 1 under bone 0: saturation both ways, truncation of negatives
		send_row(1'b0, 6'd0, mk_row(MAXW, 32'd0, 32'd0, 32'd0));
		send_row(1'b0, 6'd0, mk_row(MAXW, MAXW, 32'd0, 32'd0));
		send_row(1'b0, 6'd0, mk_row(32'd0, MINW, 32'd0, 32'd0));
		send_row(1'b0, 6'd0, mk_row(MINW, 32'd0, 32'd0, 32'hFFFF_FFFF));
		// bone 2: parent equal to itself, parent far above, then a parent per row
		send_row(1'b0, 6'd2, rand_row());
		send_row(1'b0, 6'd63, rand_row());
		send_row(1'b0, 6'd1, mk_row(32'd0, 32'd0, 32'd0, ONE));
		send_row(1'b0, 6'd0, mk_row(32'hFFFF_FFFF, 32'hFFFF_0000, ONE, MAXW));
		// restart in the middle of bone 3
		send_row(1'b0, 6'd2, rand_row());
		send_row(1'b1, 6'd5, rand_row());
		send_row(1'b0, 6'd0, rand_row());
		send_row(1'b0, 6'd0, rand_row());
		send_row(1'b0, 6'd0, rand_row());
		for (int r = 0; r < 4; r++)
			send_row(1'b0, 6'd0, rand_row());
	endtask

	task automatic test_capacity();
		int par;
		for (int b = 0; b < MAX_BONES + 2; b++) begin
			for (int r = 0; r < 4; r++) begin
				par = (b == 0) ? $urandom_range(63) : $urandom_range(b > 63 ? 63 : b - 1);
				send_row(b == 0 && r == 0, par[5:0], rand_row());
			end
		end
	endtask

	task automatic test_backpressure();
		hold_cycles = 300;
		for (int b = 0; b < 30; b++)
			for (int r = 0; r < 4; r++)
				send_row(b == 0 && r == 0, b == 0 ? 6'd0 : 6'(b - 1), rand_row());
	endtask

	task automatic run_random(input int n_items);
		int sent;
		int bones;
		int par;
		int p;
		bit cut;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				// stray request with random flags
				p = $urandom_range(63);
				send_row(1'($urandom_range(1)), p[5:0], rand_row());
				sent++;
			end else begin
				bones = ($urandom_range(29) == 0) ? $urandom_range(MAX_BONES, MAX_BONES + 4)
					: $urandom_range(1, 12);
				cut = 1'b0;
				for (int b = 0; b < bones && !cut; b++) begin
					par = (b == 0) ? $urandom_range(63)
						: $urandom_range(b > 63 ? 63 : b - 1);
					for (int r = 0; r < 4 && !cut; r++) begin
						p = par;
						case ($urandom_range(19))
							0: p = $urandom_range(63);
							1: if (b > 0) p = $urandom_range(b > 63 ? 63 : b - 1);
							2: cut = ($urandom_range(9) == 0);
							default: ;
						endcase
						if (!cut) begin
							send_row(b == 0 && r == 0, p[5:0], rand_row());
							sent++;
						end
					end
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		start_skeleton = 1'b0;
		parent_bone = '0;
		local_col0 = '0;
		local_col1 = '0;
		local_col2 = '0;
		local_col3 = '0;
		hold_cycles = 0;
		errors = 0;
		cur_bone = 0;
		cur_row = 0;
		send_idle_pct = 22;
		rcv_idle_pct = 82;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_capacity();
		run_random(380);
		send_idle_pct = 82;
		rcv_idle_pct = 22;
		run_random(380);
		send_idle_pct = 0;
		rcv_idle_pct = 0;
		test_backpressure();
		run_random(380);

		req_valid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
